// ----- sv/swac_pkg.sv -----
// ----------------------------------------------------------------------------
// swac_pkg: shared types and constants for the Sv39 walk and access checker
// Item structs, command and status codes, PTE flag positions, back-end states.
// ----------------------------------------------------------------------------
package swac_pkg;

    // default number of 512-word table pages held in memory
    localparam int TABLE_PAGES_DEFAULT = 8;

    // entries in the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    localparam int WORDS_PER_PAGE = 512;
    localparam int VPN_W          = 9;
    localparam int PFN_W          = 44;
    localparam int PFN_LSB        = 10;
    localparam int CFG_DATA_W     = 44;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WALK  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_NOT_MAPPED = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_SWAP_OK    = 3'd2;
    localparam logic [2:0] ST_SWAP_WRO   = 3'd3;
    localparam logic [2:0] ST_WRO        = 3'd4;
    localparam logic [2:0] ST_BAD        = 3'd5;

    // configuration register indexes
    localparam logic CFG_MEM_BASE_PFN = 1'b0;
    localparam logic CFG_SWAP_BIT     = 1'b1;

    localparam logic [3:0] SWAP_BIT_RESET = 4'd8;

    // PTE flag positions
    localparam int PTE_V = 0;
    localparam int PTE_W = 2;
    localparam int PTE_A = 6;
    localparam int PTE_D = 7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] word_index;
        logic [63:0] word_value;
        logic [38:0] vaddr;
        logic [2:0]  root_page;
        logic        is_store;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_data;
    } out_item_t;

    // what the back end has to do with a queued item
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_WALK,
        KIND_RESP
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] imm_status;
        in_item_t   item;
    } queue_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ_WAIT,
        BK_L2_WAIT,
        BK_L1_WAIT,
        BK_LEAF_WAIT,
        BK_DONE
    } back_state_t;

endpackage

// ----- sv/swac_ram.sv -----
// ----------------------------------------------------------------------------
// swac_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/swac_front.sv -----
// ----------------------------------------------------------------------------
// swac_front: input classifier
// Decodes the command, range-checks word index and root page, and pushes
// a queue entry; items that need no memory access carry their status.
// ----------------------------------------------------------------------------
module swac_front #(
    parameter int TABLE_PAGES = swac_pkg::TABLE_PAGES_DEFAULT
) (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  swac_pkg::in_item_t      s_item,
    input  logic                    q_full,
    output logic                    q_push,
    output swac_pkg::queue_entry_t  q_entry
);

    localparam int WORDS = TABLE_PAGES * swac_pkg::WORDS_PER_PAGE;

    logic idx_ok;
    logic root_ok;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign idx_ok  = 32'(s_item.word_index) < 32'(WORDS);
    assign root_ok = 32'(s_item.root_page) < 32'(TABLE_PAGES);

    // command decode
    always_comb begin
        q_entry.item       = s_item;
        q_entry.kind       = swac_pkg::KIND_RESP;
        q_entry.imm_status = swac_pkg::ST_NOT_MAPPED;
        unique case (s_item.cmd)
            swac_pkg::CMD_WRITE: begin
                q_entry.kind       = idx_ok ? swac_pkg::KIND_WRITE : swac_pkg::KIND_RESP;
                q_entry.imm_status = swac_pkg::ST_BAD;
            end
            swac_pkg::CMD_READ: begin
                q_entry.kind       = idx_ok ? swac_pkg::KIND_READ : swac_pkg::KIND_RESP;
                q_entry.imm_status = swac_pkg::ST_BAD;
            end
            swac_pkg::CMD_WALK: begin
                q_entry.kind       = root_ok ? swac_pkg::KIND_WALK : swac_pkg::KIND_RESP;
                q_entry.imm_status = swac_pkg::ST_BAD;
            end
            default: begin
                q_entry.kind       = swac_pkg::KIND_RESP;
                q_entry.imm_status = swac_pkg::ST_NOT_MAPPED;
            end
        endcase
    end

endmodule

// ----- sv/swac_queue.sv -----
// ----------------------------------------------------------------------------
// swac_queue: small FIFO between front and back end
// Register-based ring of classified items; head is visible while not empty.
// ----------------------------------------------------------------------------
module swac_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  swac_pkg::queue_entry_t  push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    empty,
    output swac_pkg::queue_entry_t  head
);

    localparam int DEPTH = swac_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swac_pkg::queue_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- sv/swac_back.sv -----
// ----------------------------------------------------------------------------
// swac_back: table memory sequencer
// Runs word writes, word reads and three-level walks against the table RAM,
// updates the leaf flags and holds the result in the output register.
// ----------------------------------------------------------------------------
module swac_back #(
    parameter int TABLE_PAGES = swac_pkg::TABLE_PAGES_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  swac_pkg::queue_entry_t  q_head,
    output logic                    q_pop,
    input  logic [43:0]             mem_base_pfn,
    input  logic [3:0]              swap_bit,
    output logic                    m_valid,
    input  logic                    m_ready,
    output swac_pkg::out_item_t     m_item
);

    localparam int WORDS  = TABLE_PAGES * swac_pkg::WORDS_PER_PAGE;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

    swac_pkg::back_state_t state_reg, state_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [63:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [63:0]       ram_rdata;

    logic [8:0]        vpn1_reg, vpn1_next;
    logic [8:0]        vpn0_reg, vpn0_next;
    logic              store_reg, store_next;
    logic [ADDR_W-1:0] leaf_addr_reg, leaf_addr_next;
    logic [2:0]        status_reg, status_next;
    logic [63:0]       data_reg, data_next;

    logic                m_valid_reg, m_valid_next;
    swac_pkg::out_item_t m_item_reg, m_item_next;

    logic        out_free;
    logic [43:0] pfn;
    logic [43:0] pfn_diff;
    logic        pte_valid;
    logic        pfn_ok;
    logic [PAGE_W-1:0] next_page;
    logic [15:0] leaf_low;
    logic        leaf_swapped;
    logic        leaf_ro_store;
    logic [63:0] leaf_vad;
    logic [63:0] leaf_va_d;

    swac_ram #(
        .WIDTH(64),
        .DEPTH(WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    // pointer entry check on the word just read
    assign pte_valid = ram_rdata[swac_pkg::PTE_V];
    assign pfn       = ram_rdata[swac_pkg::PFN_LSB +: swac_pkg::PFN_W];
    assign pfn_diff  = pfn - mem_base_pfn;
    assign pfn_ok    = (pfn >= mem_base_pfn) && (pfn_diff < 44'(TABLE_PAGES));
    assign next_page = pfn_diff[PAGE_W-1:0];

    // leaf flag update
    assign leaf_low      = ram_rdata[15:0];
    assign leaf_swapped  = leaf_low[swap_bit];
    assign leaf_ro_store = !ram_rdata[swac_pkg::PTE_W] && store_reg;
    assign leaf_vad      = ram_rdata | 64'((1 << swac_pkg::PTE_V) | (1 << swac_pkg::PTE_A)
                                          | (1 << swac_pkg::PTE_D));
    assign leaf_va_d     = ram_rdata | 64'(1 << swac_pkg::PTE_A)
                           | (store_reg ? 64'(1 << swac_pkg::PTE_D) : 64'd0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swac_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    unique case (q_head.kind)
                        swac_pkg::KIND_READ: state_next = swac_pkg::BK_READ_WAIT;
                        swac_pkg::KIND_WALK: state_next = swac_pkg::BK_L2_WAIT;
                        default:             state_next = swac_pkg::BK_DONE;
                    endcase
                end
            end
            swac_pkg::BK_READ_WAIT: state_next = swac_pkg::BK_DONE;
            swac_pkg::BK_L2_WAIT: begin
                state_next = (pte_valid && pfn_ok) ? swac_pkg::BK_L1_WAIT : swac_pkg::BK_DONE;
            end
            swac_pkg::BK_L1_WAIT: begin
                state_next = (pte_valid && pfn_ok) ? swac_pkg::BK_LEAF_WAIT : swac_pkg::BK_DONE;
            end
            swac_pkg::BK_LEAF_WAIT: state_next = swac_pkg::BK_DONE;
            swac_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = swac_pkg::BK_IDLE;
                end
            end
            default: state_next = swac_pkg::BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = leaf_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(q_head.item.word_index);
        vpn1_next      = vpn1_reg;
        vpn0_next      = vpn0_reg;
        store_next     = store_reg;
        leaf_addr_next = leaf_addr_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;
        unique case (state_reg)
            swac_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop       = 1'b1;
                    vpn1_next   = q_head.item.vaddr[29:21];
                    vpn0_next   = q_head.item.vaddr[20:12];
                    store_next  = q_head.item.is_store;
                    data_next   = 64'd0;
                    status_next = swac_pkg::ST_OK;
                    unique case (q_head.kind)
                        swac_pkg::KIND_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(q_head.item.word_index);
                            ram_wdata = q_head.item.word_value;
                        end
                        swac_pkg::KIND_READ: begin
                            ram_re = 1'b1;
                        end
                        swac_pkg::KIND_WALK: begin
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_W'({q_head.item.root_page,
                                                 q_head.item.vaddr[38:30]});
                        end
                        default: begin
                            status_next = q_head.imm_status;
                        end
                    endcase
                end
            end
            swac_pkg::BK_READ_WAIT: begin
                data_next   = ram_rdata;
                status_next = swac_pkg::ST_OK;
            end
            swac_pkg::BK_L2_WAIT, swac_pkg::BK_L1_WAIT: begin
                if (!pte_valid) begin
                    status_next = swac_pkg::ST_NOT_MAPPED;
                end else if (!pfn_ok) begin
                    status_next = swac_pkg::ST_BAD;
                end else begin
                    ram_re = 1'b1;
                    if (state_reg == swac_pkg::BK_L2_WAIT) begin
                        ram_raddr = ADDR_W'({next_page, vpn1_reg});
                    end else begin
                        ram_raddr      = ADDR_W'({next_page, vpn0_reg});
                        leaf_addr_next = ADDR_W'({next_page, vpn0_reg});
                    end
                end
            end
            swac_pkg::BK_LEAF_WAIT: begin
                if (leaf_swapped) begin
                    ram_we      = 1'b1;
                    ram_wdata   = leaf_ro_store ? leaf_vad
                                                : (leaf_va_d | 64'(1 << swac_pkg::PTE_V));
                    data_next   = ram_wdata;
                    status_next = leaf_ro_store ? swac_pkg::ST_SWAP_WRO : swac_pkg::ST_SWAP_OK;
                end else if (!pte_valid) begin
                    status_next = swac_pkg::ST_NOT_MAPPED;
                end else begin
                    ram_we      = 1'b1;
                    ram_wdata   = leaf_ro_store ? leaf_vad : leaf_va_d;
                    data_next   = ram_wdata;
                    status_next = leaf_ro_store ? swac_pkg::ST_WRO : swac_pkg::ST_OK;
                end
            end
            swac_pkg::BK_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_item_next.status    = status_reg;
                    m_item_next.read_data = data_reg;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swac_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        vpn1_reg      <= vpn1_next;
        vpn0_reg      <= vpn0_next;
        store_reg     <= store_next;
        leaf_addr_reg <= leaf_addr_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        m_item_reg    <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a queued item is taken only when the sequencer is free
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == swac_pkg::BK_IDLE) && !q_empty)
        else $error("queue popped while sequencer busy");

    // leaving the result state always presents a result
    a_done_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swac_pkg::BK_DONE) && out_free |=> m_valid_reg)
        else $error("result dropped on leaving done state");

    // an unaccepted result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_item_reg))
        else $error("pending result changed");

    // no memory write during pointer levels of a walk
    a_no_ptr_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swac_pkg::BK_L2_WAIT) || (state_reg == swac_pkg::BK_L1_WAIT)
        |-> !ram_we)
        else $error("table written during pointer level");

    // result status is a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_item_reg.status <= swac_pkg::ST_BAD)
        else $error("undefined status code");

endmodule

// ----- sv/sv39_walk_access_check_top.sv -----
// ----------------------------------------------------------------------------
// sv39_walk_access_check_top: Sv39 table walker with access/dirty update
// Table word memory with write/read commands and a three-level walk that
// checks one access, updates the leaf flags and reports a status.
// ----------------------------------------------------------------------------
//
//  channel   ports                          direction  transfer
//  --------  -----------------------------  ---------  ----------------------
//  input     s_valid s_ready s_item         in         valid && ready
//  result    m_valid m_ready m_item         out        valid && ready
//  config    cfg_we cfg_index cfg_wdata     in         cfg_we, no wait
//
//  Sequencing: the back-end sequencer owns the single RAM read port and, when
//  idle, pops an item in the cycle after it is accepted. A word write passes
//  through IDLE and DONE, a word read through IDLE, READ_WAIT and DONE, a full
//  walk through IDLE, L2_WAIT, L1_WAIT, LEAF_WAIT (leaf write-back) and DONE;
//  a walk that stops at level 2 or 1 goes from that wait state to DONE.
//  Reset: synchronous active-low aresetn clears control and configuration;
//  the table memory is not cleared.
//  Stalls: a two-entry queue keeps accepting until full while the back end
//  works or waits on m_ready; the output register holds one result.
// ----------------------------------------------------------------------------
module sv39_walk_access_check_top #(
    parameter int TABLE_PAGES = swac_pkg::TABLE_PAGES_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  swac_pkg::in_item_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output swac_pkg::out_item_t                  m_item,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [swac_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic [43:0] mem_base_pfn_reg;
    logic [3:0]  swap_bit_reg;

    logic                   q_full;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    swac_pkg::queue_entry_t q_entry;
    swac_pkg::queue_entry_t q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_base_pfn_reg <= 44'd0;
            swap_bit_reg     <= swac_pkg::SWAP_BIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                swac_pkg::CFG_MEM_BASE_PFN: mem_base_pfn_reg <= cfg_wdata[43:0];
                swac_pkg::CFG_SWAP_BIT:     swap_bit_reg     <= cfg_wdata[3:0];
                default:                    swap_bit_reg     <= swap_bit_reg;
            endcase
        end
    end

    swac_front #(
        .TABLE_PAGES(TABLE_PAGES)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    swac_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    swac_back #(
        .TABLE_PAGES(TABLE_PAGES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .mem_base_pfn (mem_base_pfn_reg),
        .swap_bit     (swap_bit_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule
